// ===== src/escaped_frame_receiver_macros.svh =====
// Assertion helpers for the frame receiver. They expect clk and arst_n in scope.
`ifndef ESCAPED_FRAME_RECEIVER_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/efr_pkg.sv =====
package efr_pkg;

	localparam int BUF_DEPTH = 256;
	localparam int FILL_W = $clog2(BUF_DEPTH + 1);
	// Wide enough for any fill count and for a declared length plus four.
	localparam int EXT_W = 17;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
	localparam logic [7:0] ESCAPE_XOR = 8'h20;
	localparam logic [7:0] GOOD_SUM = 8'hFF;

	typedef struct packed {
		logic [7:0] data_out;
		logic stored;
		logic [7:0] position;
		logic frame_end;
		logic checksum_ok;
		logic [15:0] frame_length;
		logic [8:0] dropped_now;
	} result_t;

	typedef struct packed {
		logic step;
		logic good;
		logic bad;
		logic [FILL_W-1:0] dropped;
	} stat_evt_t;

endpackage

// ===== src/efr_deframe.sv =====
module efr_deframe (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] rx_byte,
	output efr_pkg::result_t res,
	output efr_pkg::stat_evt_t evt
);

	logic [efr_pkg::FILL_W-1:0] fill_q;
	logic esc_q;
	logic [7:0] len_hi_q;
	logic [7:0] len_lo_q;
	logic [7:0] sum_q;

	logic [efr_pkg::FILL_W-1:0] fill_a;
	logic [efr_pkg::FILL_W-1:0] fill_n;
	logic [efr_pkg::FILL_W-1:0] fill_f;
	logic [efr_pkg::FILL_W-1:0] dropped;
	logic [efr_pkg::FILL_W-1:0] pos;
	logic esc_n;
	logic [7:0] len_hi_n;
	logic [7:0] len_lo_n;
	logic [7:0] sum_n;
	logic [7:0] sum_f;
	logic [7:0] d;
	logic [efr_pkg::EXT_W-1:0] held;
	logic [efr_pkg::EXT_W-1:0] pos_ext;
	logic [efr_pkg::EXT_W-1:0] drop_ext;
	logic [15:0] flen;
	logic stored;
	logic frame_end;
	logic ok;

	always_comb begin
		d = rx_byte;
		esc_n = esc_q;
		fill_a = fill_q;
		fill_n = fill_q;
		sum_n = sum_q;
		len_hi_n = len_hi_q;
		len_lo_n = len_lo_q;
		dropped = '0;
		pos = '0;
		stored = 1'b0;
		if (rx_byte == efr_pkg::START_BYTE) begin
			// A start byte always opens a new frame, even after an escape.
			dropped = fill_q;
			esc_n = 1'b0;
			stored = 1'b1;
			sum_n = '0;
			fill_n = efr_pkg::FILL_W'(1);
		end else begin
			if (esc_q) begin
				d = rx_byte ^ efr_pkg::ESCAPE_XOR;
				esc_n = 1'b0;
			end else if (rx_byte == efr_pkg::ESCAPE_BYTE) begin
				esc_n = 1'b1;
			end
			if (fill_q >= efr_pkg::FILL_W'(efr_pkg::BUF_DEPTH)) begin
				dropped = fill_q;
				fill_a = '0;
			end
			fill_n = fill_a;
			if (!esc_n) begin
				pos = fill_a;
				stored = 1'b1;
				if (fill_a == '0) begin
					sum_n = '0;
				end else if (fill_a == efr_pkg::FILL_W'(1)) begin
					len_hi_n = d;
				end else if (fill_a == efr_pkg::FILL_W'(2)) begin
					len_lo_n = d;
				end else begin
					sum_n = sum_q + d;
				end
				fill_n = fill_a + efr_pkg::FILL_W'(1);
			end
		end

		held = efr_pkg::EXT_W'(fill_n);
		flen = '0;
		frame_end = 1'b0;
		ok = 1'b0;
		fill_f = fill_n;
		sum_f = sum_n;
		if (held >= efr_pkg::EXT_W'(3)) begin
			flen = {len_hi_n, len_lo_n};
			if (held >= efr_pkg::EXT_W'(flen) + efr_pkg::EXT_W'(4)) begin
				frame_end = 1'b1;
				ok = (sum_n == efr_pkg::GOOD_SUM);
				fill_f = '0;
				sum_f = '0;
			end
		end
	end

	assign pos_ext = efr_pkg::EXT_W'(pos);
	assign drop_ext = efr_pkg::EXT_W'(dropped);

	always_comb begin
		res.data_out = stored ? d : 8'd0;
		res.stored = stored;
		res.position = pos_ext[7:0];
		res.frame_end = frame_end;
		res.checksum_ok = ok;
		res.frame_length = flen;
		res.dropped_now = drop_ext[8:0];
		evt.step = step;
		evt.good = frame_end && ok;
		evt.bad = frame_end && !ok;
		evt.dropped = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			esc_q <= 1'b0;
			len_hi_q <= '0;
			len_lo_q <= '0;
			sum_q <= '0;
		end else if (step) begin
			fill_q <= fill_f;
			esc_q <= esc_n;
			len_hi_q <= len_hi_n;
			len_lo_q <= len_lo_n;
			sum_q <= sum_f;
		end
	end

endmodule

// ===== src/efr_stats.sv =====
module efr_stats (
	input logic clk,
	input logic arst_n,
	input efr_pkg::stat_evt_t evt,
	output logic [31:0] good_frame_count,
	output logic [31:0] bad_frame_count,
	output logic [31:0] dropped_byte_count,
	output logic [31:0] received_byte_count
);

	logic [31:0] good_q;
	logic [31:0] bad_q;
	logic [31:0] dropped_q;
	logic [31:0] received_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q <= '0;
			bad_q <= '0;
			dropped_q <= '0;
			received_q <= '0;
		end else if (evt.step) begin
			good_q <= good_q + 32'(evt.good);
			bad_q <= bad_q + 32'(evt.bad);
			dropped_q <= dropped_q + 32'(evt.dropped);
			received_q <= received_q + 32'd1;
		end
	end

	assign good_frame_count = good_q;
	assign bad_frame_count = bad_q;
	assign dropped_byte_count = dropped_q;
	assign received_byte_count = received_q;

endmodule

// ===== src/escaped_frame_receiver.sv =====
// Receiver for byte-stuffed frames with an 8-bit sum checksum. Each raw byte
// taken on the input channel yields exactly one result item, in order. A byte
// is held in an input register, then decoded against the frame state and
// written to the result register once that register can advance, so one
// byte is taken per clock whenever the output side is not stalling. The four
// totals reported with a result are the counts after that byte, and they wrap
// at 32 bits. The frame buffer holds efr_pkg::BUF_DEPTH bytes, and a frame
// whose declared length does not fit is dropped when the buffer fills.
`include "escaped_frame_receiver_macros.svh"

module escaped_frame_receiver (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] data_out,
	output logic stored,
	output logic [7:0] position,
	output logic frame_end,
	output logic checksum_ok,
	output logic [15:0] frame_length,
	output logic [8:0] dropped_now,
	output logic [31:0] good_frame_count,
	output logic [31:0] bad_frame_count,
	output logic [31:0] dropped_byte_count,
	output logic [31:0] received_byte_count
);

	logic valid_s1;
	logic [7:0] rx_s1;
	logic valid_s2;
	efr_pkg::result_t res_s2;
	efr_pkg::result_t res;
	efr_pkg::stat_evt_t evt;
	logic advance;
	logic step;

	assign advance = !valid_s2 || !out_stall;
	assign step = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	efr_deframe u_deframe (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(rx_s1),
		.res(res),
		.evt(evt)
	);

	// The counters move only when an item enters the result register, so they
	// always match the item on display.
	efr_stats u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.good_frame_count(good_frame_count),
		.bad_frame_count(bad_frame_count),
		.dropped_byte_count(dropped_byte_count),
		.received_byte_count(received_byte_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign data_out = res_s2.data_out;
	assign stored = res_s2.stored;
	assign position = res_s2.position;
	assign frame_end = res_s2.frame_end;
	assign checksum_ok = res_s2.checksum_ok;
	assign frame_length = res_s2.frame_length;
	assign dropped_now = res_s2.dropped_now;

	`EFR_ASSERT_NOW(a_end_has_byte, valid_s2 && res_s2.frame_end, res_s2.stored, "frame end without a stored byte")
	`EFR_ASSERT_NOW(a_ok_at_end, valid_s2 && res_s2.checksum_ok, res_s2.frame_end, "checksum verdict outside frame end")
	`EFR_ASSERT_NOW(a_drop_restarts, valid_s2 && res_s2.stored && res_s2.dropped_now != 9'd0, res_s2.position == 8'd0, "byte after a drop not at position zero")
	`EFR_ASSERT_NEXT(a_rx_count, step, received_byte_count == $past(received_byte_count) + 32'd1, "received count did not advance by one")

endmodule
